FILE: hdl/crc32_reflected_byte_update_top_macros.svh
// ----------------------------------------------------------------------------
// CRC-32 reflected byte update - assertion macros
// Shared concurrent assertion forms, clocked on i_clk, off during reset.
// ----------------------------------------------------------------------------
`ifndef CRC32_REFLECTED_BYTE_UPDATE_TOP_MACROS_SVH
`define CRC32_REFLECTED_BYTE_UPDATE_TOP_MACROS_SVH

// Same-cycle implication.
`define CRC_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define CRC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hdl/crc32rb_pkg.sv
// ----------------------------------------------------------------------------
// CRC-32 reflected byte update - package
// Types, register codes and the byte fold network shared by the block.
// ----------------------------------------------------------------------------
package crc32rb_pkg;

    localparam int unsigned CRC_W   = 32;
    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned Q_DEPTH = 2;
    localparam int unsigned Q_PTR_W = 1;
    localparam int unsigned Q_CNT_W = 2;

    localparam logic [CRC_W-1:0] POLY_RESET = 32'hEDB8_8320;
    localparam logic [CRC_W-1:0] SEED_RESET = 32'h0000_0000;

    typedef enum logic [0:0] {
        REG_POLY = 1'b0,
        REG_SEED = 1'b1
    } t_reg_idx;

    // One queued byte with its message position.
    typedef struct packed {
        logic [BYTE_W-1:0] data_byte;
        logic              final_byte;
        logic              msg_start;
    } t_cmd;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

    // Eight LSB-first shift/XOR steps.
    function automatic logic [CRC_W-1:0] crc_fold(
        input logic [CRC_W-1:0]  crc_in,
        input logic [BYTE_W-1:0] data,
        input logic [CRC_W-1:0]  poly
    );
        logic [CRC_W-1:0] crc;
        logic             out_bit;
        crc = crc_in;
        for (int k = 0; k < BYTE_W; k++) begin
            out_bit = crc[0] ^ data[k];
            crc     = {1'b0, crc[CRC_W-1:1]};
            if (out_bit) begin
                crc = crc ^ poly;
            end
        end
        return crc;
    endfunction

endpackage

FILE: hdl/crc32rb_front.sv
// ----------------------------------------------------------------------------
// CRC-32 reflected byte update - front end
// Accepts bytes and tags each with whether it opens a message.
// ----------------------------------------------------------------------------
module crc32rb_front (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [crc32rb_pkg::BYTE_W-1:0]  s_axis_tdata,   // [7:0] data_byte
    input  logic                            s_axis_tlast,   // final_byte
    input  crc32rb_pkg::t_q_status          i_q_status,
    output logic                            o_push,
    output crc32rb_pkg::t_cmd               o_cmd
);
    import crc32rb_pkg::*;

    logic r_start_pending;
    logic n_start_pending;

    assign s_axis_tready = !i_q_status.full;
    assign o_push        = s_axis_tvalid && !i_q_status.full;

    assign o_cmd.data_byte  = s_axis_tdata;
    assign o_cmd.final_byte = s_axis_tlast;
    assign o_cmd.msg_start  = r_start_pending;

    // A final byte arms the restart for the byte after it.
    always_comb begin
        n_start_pending = r_start_pending;
        if (o_push) begin
            n_start_pending = s_axis_tlast;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_pending <= 1'b1;
        end else begin
            r_start_pending <= n_start_pending;
        end
    end

endmodule

FILE: hdl/crc32rb_queue.sv
// ----------------------------------------------------------------------------
// CRC-32 reflected byte update - command queue
// Two-entry FIFO between front and back ends.
// ----------------------------------------------------------------------------
module crc32rb_queue (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_push,
    input  crc32rb_pkg::t_cmd       i_cmd,
    input  logic                    i_pop,
    output crc32rb_pkg::t_cmd       o_cmd,
    output crc32rb_pkg::t_q_status  o_status
);
    import crc32rb_pkg::*;

    t_cmd               r_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0] r_wr_ptr;
    logic [Q_PTR_W-1:0] r_rd_ptr;
    logic [Q_CNT_W-1:0] r_count;
    logic [Q_CNT_W-1:0] n_count;
    logic               do_push;
    logic               do_pop;

    assign o_status.full  = (r_count == Q_CNT_W'(Q_DEPTH));
    assign o_status.empty = (r_count == '0);
    assign do_push        = i_push && !o_status.full;
    assign do_pop         = i_pop && !o_status.empty;
    assign o_cmd          = r_mem[r_rd_ptr];

    always_comb begin
        n_count = r_count;
        case ({do_push, do_pop})
            2'b10:   n_count = r_count + Q_CNT_W'(1);
            2'b01:   n_count = r_count - Q_CNT_W'(1);
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            r_count <= n_count;
        end
    end

endmodule

FILE: hdl/crc32rb_back.sv
// ----------------------------------------------------------------------------
// CRC-32 reflected byte update - back end
// Folds queued bytes into the running CRC and holds the result register.
// ----------------------------------------------------------------------------
module crc32rb_back (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic [crc32rb_pkg::CRC_W-1:0]  i_poly,
    input  logic [crc32rb_pkg::CRC_W-1:0]  i_seed,
    input  crc32rb_pkg::t_cmd              i_cmd,
    input  crc32rb_pkg::t_q_status         i_q_status,
    output logic                           o_pop,
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    output logic [crc32rb_pkg::CRC_W-1:0]  m_axis_tdata,   // [31:0] crc_value
    output logic                           m_axis_tlast    // message_end
);
    import crc32rb_pkg::*;

    logic [CRC_W-1:0] r_running_crc;
    logic [CRC_W-1:0] r_out_crc;
    logic             r_out_last;
    logic             r_out_valid;
    logic [CRC_W-1:0] crc_base;
    logic [CRC_W-1:0] crc_next;

    // Take a command whenever the result slot is free or being drained.
    assign o_pop    = !i_q_status.empty && (!r_out_valid || m_axis_tready);
    assign crc_base = i_cmd.msg_start ? i_seed : r_running_crc;
    assign crc_next = crc_fold(crc_base, i_cmd.data_byte, i_poly);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_running_crc <= SEED_RESET;
        end else if (o_pop) begin
            r_running_crc <= crc_next;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_out_crc  <= crc_next;
            r_out_last <= i_cmd.final_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_pop) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_crc;
    assign m_axis_tlast  = r_out_last;

endmodule

FILE: hdl/crc32_reflected_byte_update_top.sv
// ----------------------------------------------------------------------------
// CRC-32 reflected byte update - top level
// Running reflected CRC-32, one data byte per request, configurable
// polynomial and seed, no final XOR.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Payload                          Accept when
//  --------  ---------  -------------------------------  ---------------------------
//  s_axis    in         tdata[7:0] byte, tlast = final   s_axis_tvalid & s_axis_tready
//  m_axis    out        tdata[31:0] CRC, tlast = end     m_axis_tvalid & m_axis_tready
//  cfg       in         index 0 poly, 1 seed; data[31:0] i_cfg_valid & o_cfg_ready
//
//  One byte per cycle sustained while m_axis keeps accepting; a byte reaches
//  m_axis through the queue entry, then the fold register. The fold is the
//  combinational eight-step shift/XOR network, which sets the clock path.
//  Synchronous active-low reset: polynomial 0xEDB88320, seed 0, next byte
//  starts a message, queue and result register empty. No clearing pass.
//  A stalled m_axis holds its result; the two-entry queue keeps taking
//  bytes until full, then drops s_axis_tready.
//  The config channel is always ready; write it only while the block is idle.
//
`include "crc32_reflected_byte_update_top_macros.svh"

module crc32_reflected_byte_update_top (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // byte input
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    input  logic [crc32rb_pkg::BYTE_W-1:0] s_axis_tdata,   // [7:0] data_byte
    input  logic                           s_axis_tlast,   // final_byte
    // CRC output
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    output logic [crc32rb_pkg::CRC_W-1:0]  m_axis_tdata,   // [31:0] crc_value
    output logic                           m_axis_tlast,   // message_end
    // register writes
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic                           i_cfg_index,
    input  logic [crc32rb_pkg::CRC_W-1:0]  i_cfg_data
);
    import crc32rb_pkg::*;

    logic [CRC_W-1:0] r_poly;
    logic [CRC_W-1:0] r_seed;
    logic             cfg_write;
    logic             push;
    logic             pop;
    t_cmd             front_cmd;
    t_cmd             queue_cmd;
    t_q_status        q_status;

    // Registers take a write in any cycle.
    assign o_cfg_ready = 1'b1;
    assign cfg_write   = i_cfg_valid && o_cfg_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_poly <= POLY_RESET;
            r_seed <= SEED_RESET;
        end else if (cfg_write) begin
            unique case (t_reg_idx'(i_cfg_index))
                REG_POLY: r_poly <= i_cfg_data;
                REG_SEED: r_seed <= i_cfg_data;
                default:  r_poly <= r_poly;
            endcase
        end
    end

    // Front end: accept the byte and mark message starts.
    crc32rb_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .i_q_status    (q_status),
        .o_push        (push),
        .o_cmd         (front_cmd)
    );

    // Decouple intake from result drain.
    crc32rb_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_cmd    (front_cmd),
        .i_pop    (pop),
        .o_cmd    (queue_cmd),
        .o_status (q_status)
    );

    // Back end: fold and present the result.
    crc32rb_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_poly        (r_poly),
        .i_seed        (r_seed),
        .i_cmd         (queue_cmd),
        .i_q_status    (q_status),
        .o_pop         (pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    // A final byte makes the next queued byte restart from the seed.
    `CRC_ASSERT_NEXT(a_restart_after_final, push && s_axis_tlast, front_cmd.msg_start,
        "byte after final byte not marked as message start")

    // A waiting command with a free result slot shows up on the output.
    `CRC_ASSERT_NEXT(a_drain_to_output, !q_status.empty && !m_axis_tvalid, m_axis_tvalid,
        "queued byte did not reach the result register")

    // Intake stalls only when the queue is full.
    `CRC_ASSERT_NOW(a_ready_when_room, !q_status.full, s_axis_tready,
        "input stalled while the queue has room")

endmodule

FILE: test/crc32rb_checker.sv
// ----------------------------------------------------------------------------
// CRC-32 reflected byte update - stream checker
// Watches the byte, CRC and register channels, predicts each CRC request from
// its own copy of polynomial, seed and running value, and compares in order.
// ----------------------------------------------------------------------------
module crc32rb_checker
    import crc32rb_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              s_axis_tvalid,
    input  logic              s_axis_tready,
    input  logic [BYTE_W-1:0] s_axis_tdata,
    input  logic              s_axis_tlast,
    input  logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    input  logic [CRC_W-1:0]  m_axis_tdata,
    input  logic              m_axis_tlast,
    input  logic              i_cfg_valid,
    input  logic              o_cfg_ready,
    input  logic              i_cfg_index,
    input  logic [CRC_W-1:0]  i_cfg_data,
    output int                o_fail_count,
    output int                o_pending,
    output int                o_bytes,
    output int                o_messages,
    output int                o_reg_writes
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [CRC_W-1:0] crc_value;
        logic             message_end;
    } crc_result_t;

    logic [CRC_W-1:0] poly_value;
    logic [CRC_W-1:0] seed_value;
    logic [CRC_W-1:0] running_crc;
    logic             msg_start;
    crc_result_t      expected_crcs[$];

    // Shift right, fold in the polynomial when the outgoing bit differs from data.
    function automatic logic [CRC_W-1:0] fold_lsb_first(
        input logic [CRC_W-1:0]  crc,
        input logic [BYTE_W-1:0] data,
        input logic [CRC_W-1:0]  poly
    );
        logic [CRC_W-1:0] r;
        r = crc;
        for (int k = 0; k < BYTE_W; k++) begin
            r = (r >> 1) ^ (((r[0] ^ data[k]) == 1'b1) ? poly : '0);
        end
        return r;
    endfunction

    always @(posedge i_clk) begin : track
        crc_result_t      want;
        logic [CRC_W-1:0] start_crc;
        if (!i_rst_n) begin
            poly_value  = POLY_RESET;
            seed_value  = SEED_RESET;
            running_crc = SEED_RESET;
            msg_start   = 1'b1;
            expected_crcs.delete();
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (expected_crcs.size() == 0) begin
                    o_fail_count++;
                    $display("%0t: unexpected crc request: crc %h last %b",
                             $time, m_axis_tdata, m_axis_tlast);
                end else begin
                    want = expected_crcs.pop_front();
                    if (m_axis_tdata !== want.crc_value) begin
                        o_fail_count++;
                        $display("%0t: crc_value mismatch: expected %h, actual %h",
                                 $time, want.crc_value, m_axis_tdata);
                    end
                    if (m_axis_tlast !== want.message_end) begin
                        o_fail_count++;
                        $display("%0t: message_end mismatch: expected %b, actual %b",
                                 $time, want.message_end, m_axis_tlast);
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready) begin
                start_crc   = msg_start ? seed_value : running_crc;
                running_crc = fold_lsb_first(start_crc, s_axis_tdata, poly_value);
                msg_start   = s_axis_tlast;
                want.crc_value   = running_crc;
                want.message_end = s_axis_tlast;
                expected_crcs.push_back(want);
                o_bytes++;
                if (s_axis_tlast) begin
                    o_messages++;
                end
            end
            if (i_cfg_valid && o_cfg_ready) begin
                case (t_reg_idx'(i_cfg_index))
                    REG_POLY: poly_value = i_cfg_data;
                    REG_SEED: seed_value = i_cfg_data;
                    default: ;
                endcase
                o_reg_writes++;
            end
        end
        o_pending = expected_crcs.size();
    end

endmodule

FILE: test/tb_top.sv
// ----------------------------------------------------------------------------
// CRC-32 reflected byte update - testbench top
// Drives bytes in bursts and register writes between phases, stalls the CRC
// side on shifting patterns, and reports the checker's verdict.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import crc32rb_pkg::*;

    localparam int CLK_PERIOD      = 10;
    localparam int RESET_CYCLES    = 10;
    localparam int NUM_PHASES      = 8;
    localparam int PHASE_BYTES     = 136;
    localparam int HOLD_OFF_PHASE  = 3;
    localparam int HOLD_OFF_CYCLES = 80;
    localparam int CFG_SETTLE      = 4;
    localparam int DRAIN_TAIL      = 10;
    localparam int QUIET_LIMIT     = 2000;

    // Receiver stall patterns.
    typedef enum int {
        RX_ALWAYS,
        RX_COIN,
        RX_SPARSE,
        RX_MOSTLY
    } t_rx_mode;

    logic              i_clk         = 1'b0;
    logic              i_rst_n       = 1'b0;
    logic              s_axis_tvalid = 1'b0;
    logic              s_axis_tready;
    logic [BYTE_W-1:0] s_axis_tdata  = '0;   // [7:0] data_byte
    logic              s_axis_tlast  = 1'b0; // final_byte
    logic              m_axis_tvalid;
    logic              m_axis_tready = 1'b0;
    logic [CRC_W-1:0]  m_axis_tdata;         // [31:0] crc_value
    logic              m_axis_tlast;         // message_end
    logic              i_cfg_valid   = 1'b0;
    logic              o_cfg_ready;
    logic              i_cfg_index   = 1'b0;
    logic [CRC_W-1:0]  i_cfg_data    = '0;

    logic hold_req = 1'b0;
    int   fail_count, pending, bytes_seen, messages_seen, reg_writes;
    int   quiet_cycles    = 0;
    int   in_stall_cycles = 0;
    int   burst_left      = 0;

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    crc32_reflected_byte_update_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    crc32rb_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .o_fail_count  (fail_count),
        .o_pending     (pending),
        .o_bytes       (bytes_seen),
        .o_messages    (messages_seen),
        .o_reg_writes  (reg_writes)
    );

    // Offer one byte request and hold it until taken. Open a new burst with
    // a random gap when the current one runs out; a zero gap keeps the
    // stream back to back.
    task automatic send_byte(input logic [BYTE_W-1:0] data_byte, input logic final_byte);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
            if (gap != 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= data_byte;
        s_axis_tlast  <= final_byte;
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    // Drop the byte stream, wait for every CRC request to come back, let the
    // pipeline settle, then write one register.
    task automatic write_reg(input t_reg_idx idx, input logic [CRC_W-1:0] value);
        s_axis_tvalid <= 1'b0;
        burst_left = 0;
        repeat (2) @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (CFG_SETTLE) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
    endtask

    // Favor the extremes and the standard polynomial over plain random words.
    function automatic logic [CRC_W-1:0] pick_word();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return '1;
            2:       return POLY_RESET;
            default: return $urandom();
        endcase
    endfunction

    // Receiver: keep switching between randomly chosen stall patterns; once, on
    // request, hold off long enough for the byte queue to fill.
    initial begin : rx_pattern
        t_rx_mode mode;
        int       mode_left;
        bit       hold_done;
        mode      = RX_ALWAYS;
        mode_left = 0;
        hold_done = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req && !hold_done) begin
                hold_done = 1'b1;
                m_axis_tready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge i_clk);
            end
            if (mode_left == 0) begin
                mode      = t_rx_mode'($urandom_range(0, 3));
                mode_left = $urandom_range(30, 200);
            end
            mode_left--;
            case (mode)
                RX_ALWAYS: m_axis_tready <= 1'b1;
                RX_COIN:   m_axis_tready <= 1'($urandom_range(0, 1));
                RX_SPARSE: m_axis_tready <= ($urandom_range(0, 3) == 0);
                default:   m_axis_tready <= ($urandom_range(0, 7) != 0);
            endcase
        end
    end

    // Watchdog on cycles without any accepted request; also count input stalls.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            quiet_cycles <= 0;
        end else if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
                     || (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == QUIET_LIMIT) begin
            $display("status: fail");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (i_rst_n && s_axis_tvalid && !s_axis_tready) begin
            in_stall_cycles <= in_stall_cycles + 1;
        end
    end

    initial begin : stimulus
        int bytes_left;
        bytes_left = 0;

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset defaults: single-byte messages at both data extremes.
        send_byte(8'h00, 1'b1);
        send_byte(8'hFF, 1'b1);
        // Three-byte message with one bit set at each end of the first two.
        send_byte(8'h01, 1'b0);
        send_byte(8'h80, 1'b0);
        send_byte(8'hA5, 1'b1);
        // Zero polynomial, all-ones seed.
        write_reg(REG_POLY, '0);
        write_reg(REG_SEED, '1);
        send_byte(8'h5A, 1'b0);
        send_byte(8'hC3, 1'b1);
        // All-ones polynomial, zero seed.
        write_reg(REG_POLY, '1);
        write_reg(REG_SEED, '0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h00, 1'b1);
        // Seed change mid-message: the open message keeps its running value,
        // the next one starts from the new seed.
        write_reg(REG_POLY, POLY_RESET);
        send_byte(8'h31, 1'b0);
        send_byte(8'h32, 1'b0);
        write_reg(REG_SEED, 32'h1234_5678);
        send_byte(8'h33, 1'b1);
        send_byte(8'h34, 1'b1);
        // Polynomial change mid-message: applies from the next byte on.
        send_byte(8'h6B, 1'b0);
        write_reg(REG_POLY, 32'h82F6_3B78);
        send_byte(8'h9E, 1'b1);

        // Random messages, mostly short with the odd long one. Messages run
        // across phase boundaries, so register writes also land mid-message.
        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            if (ph % 2 == 0) begin
                write_reg(REG_POLY, pick_word());
                write_reg(REG_SEED, pick_word());
            end else begin
                write_reg(t_reg_idx'($urandom_range(0, 1)), pick_word());
            end
            for (int n = 0; n < PHASE_BYTES; n++) begin
                if (bytes_left == 0) begin
                    bytes_left = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 64)
                                                            : $urandom_range(1, 8);
                end
                bytes_left--;
                send_byte(BYTE_W'($urandom_range(0, 255)), bytes_left == 0);
                if (ph == HOLD_OFF_PHASE && n == 20) begin
                    hold_req <= 1'b1;
                end
            end
        end

        // Drain the CRC side, then allow the pipeline to go quiet.
        s_axis_tvalid <= 1'b0;
        repeat (2) @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_TAIL) @(posedge i_clk);

        $display("covered %0d bytes in %0d complete messages across %0d register writes",
                 bytes_seen, messages_seen, reg_writes);
        $display("byte input stalled for %0d cycles; one output hold-off of %0d cycles",
                 in_stall_cycles, HOLD_OFF_CYCLES);
        if (fail_count == 0 && pending == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
